// ===== sv/bfp_pkg.sv =====
// shared types and constants for the byte fifo with peak tracking and word pops
// no dependencies
`default_nettype none

package bfp_pkg;

   localparam int OPCODE_W = 3;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int LEVEL_W  = 9;
   localparam int NEED_W   = 3;

   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP8   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP16  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP32  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_STATUS = 3'd5;

   localparam logic [NEED_W-1:0] NEED_BYTE = 3'd1;
   localparam logic [NEED_W-1:0] NEED_HALF = 3'd2;
   localparam logic [NEED_W-1:0] NEED_WORD = 3'd4;

   typedef enum logic [1:0] {
      KIND_PUSH,
      KIND_POP,
      KIND_CLEAR,
      KIND_STATUS
   } kind_type;

   // classified command handed from the front end to the back end
   typedef struct packed {
      kind_type                 kind;
      logic [NEED_W-1:0]        need;
      logic [BYTE_W-1:0]        data;
   } cmd_type;

endpackage

`default_nettype wire

// ===== sv/bfp_ifs.sv =====
// valid/ready channel interfaces for requests and responses
// depends on bfp_pkg
`default_nettype none

interface bfp_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfp_pkg::OPCODE_W-1:0]  opcode;
   logic [bfp_pkg::BYTE_W-1:0]    data_byte;

   modport source (output valid, opcode, data_byte, input ready);
   modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface bfp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfp_pkg::WORD_W-1:0]    read_value;
   logic                          ok;
   logic [bfp_pkg::LEVEL_W-1:0]   occupancy;
   logic [bfp_pkg::LEVEL_W-1:0]   peak_level;

   modport source (output valid, read_value, ok, occupancy, peak_level, input ready);
   modport sink   (input valid, read_value, ok, occupancy, peak_level, output ready);
endinterface

`default_nettype wire

// ===== sv/bfp_front.sv =====
// front end: accepts requests, decodes the opcode and queues commands
// depends on bfp_pkg and bfp_ifs
`default_nettype none

module bfp_front (
   input  wire logic       clock,
   input  wire logic       reset,
   bfp_req_if.sink         req_if,
   output bfp_pkg::cmd_type cmd,
   output logic            cmd_valid,
   input  wire logic       cmd_ready
);

   localparam int QUEUE_DEPTH = 2;

   bfp_pkg::cmd_type queue_ff [QUEUE_DEPTH];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push_q;
   logic             pop_q;
   bfp_pkg::cmd_type decoded;

   function automatic bfp_pkg::cmd_type decode(
      input logic [bfp_pkg::OPCODE_W-1:0] opcode,
      input logic [bfp_pkg::BYTE_W-1:0]   data_byte
   );
      bfp_pkg::cmd_type c;
      c.data = data_byte;
      c.need = bfp_pkg::NEED_BYTE;
      case (opcode)
         bfp_pkg::OP_PUSH: begin
            c.kind = bfp_pkg::KIND_PUSH;
         end
         bfp_pkg::OP_POP8: begin
            c.kind = bfp_pkg::KIND_POP;
         end
         bfp_pkg::OP_POP16: begin
            c.kind = bfp_pkg::KIND_POP;
            c.need = bfp_pkg::NEED_HALF;
         end
         bfp_pkg::OP_POP32: begin
            c.kind = bfp_pkg::KIND_POP;
            c.need = bfp_pkg::NEED_WORD;
         end
         bfp_pkg::OP_CLEAR: begin
            c.kind = bfp_pkg::KIND_CLEAR;
         end
         // status and the unused codes only report
         default: begin
            c.kind = bfp_pkg::KIND_STATUS;
         end
      endcase
      return c;
   endfunction

   assign decoded      = decode(req_if.opcode, req_if.data_byte);
   assign req_if.ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push_q       = req_if.valid && req_if.ready;
   assign cmd_valid    = (count_ff != 2'd0);
   assign cmd          = queue_ff[rd_ptr_ff];
   assign pop_q        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push_q ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_q ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_q) - 2'(pop_q);
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/bfp_back.sv =====
// back end: byte store, pointers, peak tracking and the pop sequencer
// depends on bfp_pkg and bfp_ifs
`default_nettype none

module bfp_back #(
   parameter int FIFO_DEPTH = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bfp_pkg::cmd_type cmd,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   bfp_rsp_if.source             rsp_if
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int PW = $clog2(FIFO_DEPTH + 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_FINISH
   } state_type;

   logic [bfp_pkg::BYTE_W-1:0] byte_store_ff [FIFO_DEPTH];
   logic [bfp_pkg::BYTE_W-1:0] rdata_ff;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [AW-1:0]               rp_ff, rp_in;
   logic                        full_ff, full_in;
   logic [PW-1:0]               peak_ff, peak_in;
   logic [bfp_pkg::WORD_W-1:0]  value_ff, value_in;
   logic                        ok_ff, ok_in;
   logic [bfp_pkg::NEED_W-1:0]  need_ff, need_in;
   logic [bfp_pkg::NEED_W-1:0]  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bfp_pkg::WORD_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [bfp_pkg::LEVEL_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic [bfp_pkg::LEVEL_W-1:0] rsp_peak_ff, rsp_peak_in;

   logic          start;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] wp_next;
   logic [CW-1:0] held;
   logic [1:0]    cap_sel;
   logic [PW-1:0] peak_now;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // bytes held, from the registered pointers
   always_comb begin
      if (full_ff) begin
         held = CW'(FIFO_DEPTH);
      end else if (wp_ff >= rp_ff) begin
         held = CW'(wp_ff) - CW'(rp_ff);
      end else begin
         held = CW'(FIFO_DEPTH) + CW'(wp_ff) - CW'(rp_ff);
      end
   end

   assign wp_next   = next_ptr(wp_ff);
   assign cmd_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign start     = cmd_valid && cmd_ready;
   assign cap_sel   = 2'(idx_ff - 3'd1);
   assign peak_now  = (PW'(held) > peak_ff) ? PW'(held) : peak_ff;
   assign mem_re    = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      full_in      = full_ff;
      peak_in      = peak_ff;
      value_in     = value_ff;
      ok_in        = ok_ff;
      need_in      = need_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_peak_in  = rsp_peak_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = '0;
               ok_in    = 1'b1;
               need_in  = cmd.need;
               idx_in   = '0;
               state_in = ST_FINISH;
               case (cmd.kind)
                  bfp_pkg::KIND_PUSH: begin
                     if (full_ff) begin
                        // dropped byte pins the peak above the depth
                        ok_in   = 1'b0;
                        peak_in = PW'(FIFO_DEPTH + 1);
                     end else begin
                        mem_we  = 1'b1;
                        wp_in   = wp_next;
                        full_in = (wp_next == rp_ff);
                     end
                  end
                  bfp_pkg::KIND_POP: begin
                     if (held < CW'(cmd.need)) begin
                        ok_in = 1'b0;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  bfp_pkg::KIND_CLEAR: begin
                     wp_in   = '0;
                     rp_in   = '0;
                     full_in = 1'b0;
                     peak_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // read data is registered, so it lags the address into the next cycle
            if (idx_ff != 3'd0) begin
               value_in[8*cap_sel +: 8] = rdata_ff;
            end
            rp_in   = next_ptr(rp_ff);
            full_in = 1'b0;
            idx_in  = idx_ff + 3'd1;
            if (idx_ff + 3'd1 == need_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            value_in[8*cap_sel +: 8] = rdata_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            peak_in      = peak_now;
            rsp_valid_in = 1'b1;
            rsp_value_in = value_ff;
            rsp_ok_in    = ok_ff;
            rsp_occ_in   = bfp_pkg::LEVEL_W'(held);
            rsp_peak_in  = bfp_pkg::LEVEL_W'(peak_now);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_store_ff[wp_ff] <= cmd.data;
      end
      if (mem_re) begin
         rdata_ff <= byte_store_ff[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      ok_ff        <= ok_in;
      need_ff      <= need_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_peak_ff  <= rsp_peak_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         full_ff      <= 1'b0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         full_ff      <= full_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = rsp_value_ff;
   assign rsp_if.ok         = rsp_ok_ff;
   assign rsp_if.occupancy  = rsp_occ_ff;
   assign rsp_if.peak_level = rsp_peak_ff;

endmodule

`default_nettype wire

// ===== sv/byte_fifo_with_peak_and_word_pop.sv =====
// top level: byte fifo with high-water mark and 16/32-bit little-endian pops
// depends on bfp_pkg, bfp_ifs, bfp_front and bfp_back
//
//   channel  dir  handshake    payload
//   req_if   in   valid/ready  opcode[2:0], data_byte[7:0]
//   rsp_if   out  valid/ready  read_value[31:0], ok, occupancy[8:0], peak_level[8:0]
//
// the front end queues up to two decoded commands, registered at the transfer
// back end: push, clear and status go from idle to finish; an n-byte pop passes
// through read once per byte, then last and finish; the byte store reads one byte a cycle
// a held response stalls the back end; the command queue takes requests until full
// synchronous reset empties the fifo and zeroes the peak; no store clearing pass
`default_nettype none

module byte_fifo_with_peak_and_word_pop #(
   parameter int FIFO_DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   bfp_req_if.sink   req_if,
   bfp_rsp_if.source rsp_if
);

   bfp_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_ready;

   bfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   bfp_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .rsp_if    (rsp_if)
   );

   // a refused pop or dropped byte never carries data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ok |-> rsp_if.read_value == '0)
      else $error("refused operation returned nonzero data");

   // the peak never sits below the reported occupancy, checked while FIFO_DEPTH is under 511
   a_peak_cover: assert property (@(posedge clock) disable iff (reset)
      (FIFO_DEPTH < 511) && rsp_if.valid |-> rsp_if.occupancy <= rsp_if.peak_level)
      else $error("peak below occupancy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
